[design/dtbl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dtbl_pkg
// Shared types and constants of the dual token bucket limiter.
// ----------------------------------------------------------------------------
package dtbl_pkg;

    // Timing of the refill clock and the largest burst.
    localparam int STEP_TICKS       = 16;
    localparam int TICKS_PER_SECOND = 1024;
    localparam int MAX_BURST        = 2147483647;

    // Both divisors are powers of two, so they become plain shifts.
    localparam int STEP_SHIFT = $clog2(STEP_TICKS);
    localparam int RATE_DIV   = TICKS_PER_SECOND / STEP_TICKS;
    localparam int RATE_SHIFT = $clog2(RATE_DIV);

    // Widths of the whole step count, the per-step rate and their product.
    // The adder needs two bits above the product, since a level added to the
    // largest product must still read as positive.
    localparam int STEPS_W = 32 - STEP_SHIFT;
    localparam int RPS_W   = 32 - RATE_SHIFT;
    localparam int PROD_W  = STEPS_W + RPS_W;
    localparam int CNT_W   = $clog2(RPS_W);
    localparam int ALU_W   = PROD_W + 2;

    // Register reset values.
    localparam logic [31:0] RATE_RESET  = 32'd1048576;
    localparam logic [30:0] BURST_RESET = 31'd1048576;
    localparam logic [30:0] MAX_BURST_V = 31'(MAX_BURST);

    // Configuration register indexes.
    localparam logic CFG_RATE  = 1'b0;
    localparam logic CFG_BURST = 1'b1;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_REFILL = 2'd0,
        REQ_DEC    = 2'd1,
        REQ_RESET  = 2'd2,
        REQ_CLAMP  = 2'd3
    } t_req;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_RD   = 5'b00100,
        S_WR   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage : dtbl_pkg
`default_nettype wire

[design/dual_token_bucket_limiter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter_unit
// Read and write token buckets with timed refill, decrement, reset and clamp.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream (i_s_*): tuser carries the request kind
// and tdata the timestamp and the two byte counts. Every request yields one
// result item on the master stream (o_m_*) with the four transition flags and
// both token levels after the request. The configuration channel (i_cfg_*)
// writes the rate (index 0) or the burst (index 1); it is always ready and
// should only be used while no item is in flight.
// One request is handled at a time. A refill with at least one whole step
// elapsed multiplies steps by the per-step rate in shift-and-add steps, one
// per bit of the rate (S_MUL), then uses the shared adder for each bucket in
// turn (S_RD, S_WR) and loads the output register (S_OUT); the next request
// is taken once the result is in that register. Decrement, reset and clamp
// skip the multiply, and a refill with no whole step elapsed goes straight
// to S_OUT.
// Reset loads the register defaults, fills both buckets to the burst and
// clears the refill stamp. A finished result waits in the output register;
// while it is not taken one more item can be processed, which then waits for
// the register, and the input is not ready meanwhile.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter_unit
    import dtbl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // tdata, from bit 0: now_stamp[31:0], read_bytes[30:0], write_bytes[30:0],
    // two zero pad bits.
    input  wire logic [95:0] i_s_tdata,
    // tuser, from bit 0: req_type[1:0].
    input  wire logic [1:0]  i_s_tuser,
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // tdata, from bit 0: read_refilled, write_refilled, read_emptied,
    // write_emptied, read_level[31:0], write_level[31:0], four zero pad bits.
    output logic [71:0]      o_m_tdata,
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [31:0] r_rate;
    logic [30:0] r_burst;

    // Bucket state.
    logic signed [31:0] r_read_tokens;
    logic signed [31:0] r_write_tokens;
    logic [31:0]        r_stamp;

    // Latched request.
    t_req        r_req;
    logic [30:0] r_nr;
    logic [30:0] r_nw;

    // Sequencer and multiplier registers.
    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEPS_W-1:0] r_mcand;
    logic [STEPS_W-1:0] r_acc;
    logic [RPS_W-1:0]   r_mplier;

    // Flags of the item in flight.
    logic r_rr, r_wr, r_re, r_we;

    // Output register.
    logic        r_out_valid;
    logic [71:0] r_out_data;

    logic               accept;
    logic [31:0]        elapsed;
    logic [STEPS_W-1:0] steps;
    logic [30:0]        burst;
    logic [STEPS_W:0]   mul_sum;
    logic [PROD_W-1:0]  prod;
    logic               sel_rd;
    logic signed [31:0] lvl;
    logic [30:0]        dec_n;

    // Shared adder and comparator.
    logic signed [ALU_W-1:0] alu_a;
    logic signed [ALU_W-1:0] alu_b;
    logic signed [ALU_W-1:0] alu_sum;
    logic signed [ALU_W-1:0] burst_x;
    logic signed [ALU_W-1:0] min_x;
    logic signed [31:0]      n_level;
    logic                    n_flag;

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Effective burst is the register limited to the maximum burst.
    assign burst   = (r_burst > MAX_BURST_V) ? MAX_BURST_V : r_burst;
    assign elapsed = i_s_tdata[31:0] - r_stamp;
    assign steps   = elapsed[31:STEP_SHIFT];

    // One shift-and-add step: add the step count when the low rate bit is set.
    assign mul_sum = {1'b0, r_acc} + (r_mplier[0] ? {1'b0, r_mcand} : '0);
    assign prod    = {r_acc, r_mplier};

    assign sel_rd = (r_state == S_RD);
    assign lvl    = sel_rd ? r_read_tokens : r_write_tokens;
    assign dec_n  = sel_rd ? r_nr : r_nw;

    always_comb begin
        burst_x = $signed({{(ALU_W - 31){1'b0}}, burst});
        min_x   = $signed({{(ALU_W - 31){1'b1}}, 31'd0});
        alu_a   = $signed({{(ALU_W - 32){lvl[31]}}, lvl});
        if (r_req == REQ_DEC) begin
            alu_b = $signed(~{{(ALU_W - 31){1'b0}}, dec_n});
        end else begin
            alu_b = $signed({2'b00, prod});
        end
        alu_sum = alu_a + alu_b + ((r_req == REQ_DEC) ? ALU_W'(1) : ALU_W'(0));

        n_level = lvl;
        n_flag  = 1'b0;
        case (r_req)
            REQ_REFILL: begin
                // Only a level below the burst is topped up.
                if (alu_a < burst_x) begin
                    n_level = (alu_sum > burst_x) ? $signed({1'b0, burst})
                                                  : alu_sum[31:0];
                end
                n_flag = (lvl <= 0) && (n_level > 0);
            end
            REQ_DEC: begin
                n_level = (alu_sum < min_x) ? alu_sum[31:0] & 32'sh8000_0000
                                            : alu_sum[31:0];
                if (alu_sum < min_x) begin
                    n_level = $signed(32'h8000_0000);
                end
                n_flag = (lvl > 0) && (alu_sum <= 0);
            end
            REQ_RESET: begin
                n_level = $signed({1'b0, burst});
            end
            REQ_CLAMP: begin
                if (alu_a > burst_x) begin
                    n_level = $signed({1'b0, burst});
                end
            end
            default: begin
                n_level = lvl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate         <= RATE_RESET;
            r_burst        <= BURST_RESET;
            r_read_tokens  <= $signed({1'b0, BURST_RESET});
            r_write_tokens <= $signed({1'b0, BURST_RESET});
            r_stamp        <= '0;
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_rr           <= 1'b0;
            r_wr           <= 1'b0;
            r_re           <= 1'b0;
            r_we           <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RATE:  r_rate  <= i_cfg_data;
                    CFG_BURST: r_burst <= i_cfg_data[30:0];
                    default:   r_rate  <= r_rate;
                endcase
            end

            // The output register fills as an item leaves the sequencer and
            // empties when the receiver takes its item.
            if (r_state == S_OUT && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= t_req'(i_s_tuser);
                        r_nr     <= i_s_tdata[62:32];
                        r_nw     <= i_s_tdata[93:63];
                        r_mcand  <= steps;
                        r_acc    <= '0;
                        r_mplier <= r_rate[31:RATE_SHIFT];
                        r_cnt    <= '0;
                        r_rr     <= 1'b0;
                        r_wr     <= 1'b0;
                        r_re     <= 1'b0;
                        r_we     <= 1'b0;
                        case (t_req'(i_s_tuser))
                            REQ_REFILL: begin
                                // Less than one whole step: nothing changes.
                                if (steps != '0) begin
                                    r_stamp <= i_s_tdata[31:0];
                                    r_state <= S_MUL;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_RESET: begin
                                r_stamp <= i_s_tdata[31:0];
                                r_state <= S_RD;
                            end
                            default: begin
                                r_state <= S_RD;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_acc    <= mul_sum[STEPS_W:1];
                    r_mplier <= {mul_sum[0], r_mplier[RPS_W-1:1]};
                    r_cnt    <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(RPS_W - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_read_tokens <= n_level;
                    if (r_req == REQ_REFILL) begin
                        r_rr <= n_flag;
                    end
                    if (r_req == REQ_DEC) begin
                        r_re <= n_flag;
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_write_tokens <= n_level;
                    if (r_req == REQ_REFILL) begin
                        r_wr <= n_flag;
                    end
                    if (r_req == REQ_DEC) begin
                        r_we <= n_flag;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload, loaded as the item leaves the sequencer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_m_tready)) begin
            r_out_data <= {4'b0000, r_write_tokens, r_read_tokens,
                           r_we, r_re, r_wr, r_rr};
        end
    end

`ifndef SYNTH
    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("request accepted while previous one still in flight");

    // The multiply never runs past the width of the per-step rate.
    a_mul_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= CNT_W'(RPS_W - 1)))
        else $error("multiply iteration count overrun");

    // A bucket cannot be both refilled and emptied by one request.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !((o_m_tdata[0] || o_m_tdata[1]) && (o_m_tdata[2] || o_m_tdata[3])))
        else $error("refill and empty flags set together");

    // Leaving the output state always presents a result.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_m_tready)) |=> o_m_tvalid)
        else $error("finished item not presented");
`endif

endmodule : dual_token_bucket_limiter_unit
`default_nettype wire
